@@ sv/assert_macros.svh @@
// assertion macros for the halo bias evaluation unit
// expects a clock named aclk and an active-low reset named aresetn in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, off while in reset
`define EHB_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// implication in the next cycle, also checked through reset
`define EHB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/ehb_pkg.sv @@
// shared types, constants and constant functions for the halo bias unit
// no dependencies
`timescale 1ns / 1ps

package ehb_pkg;

    localparam int LOG_W   = 40;   // signed q.24 log values
    localparam int LIN_W   = 61;   // unsigned q.32 linear values, capped at 2^60
    localparam int STEPS   = 24;   // fraction bits of a log
    localparam int LOG_LAT = STEPS + 1;
    localparam int EXP_LAT = STEPS + 2;
    localparam int DIV_LAT = 33;

    localparam logic [28:0] Q28_ONE = 29'h1000_0000;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SAT     = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic [1:0] REG_DC = 2'd0;
    localparam logic [1:0] REG_A  = 2'd1;
    localparam logic [1:0] REG_B  = 2'd2;
    localparam logic [1:0] REG_C  = 2'd3;

    localparam logic [31:0] RST_DC = 32'd452582179;
    localparam logic [31:0] RST_A  = 32'd189783867;
    localparam logic [31:0] RST_B  = 32'd134217728;
    localparam logic [28:0] RST_C  = 29'd161061274;

    typedef struct packed {
        logic             cap;
        logic [LIN_W-1:0] val;
    } exp_out_t;

    typedef struct packed {
        logic             cap1;
        logic             cap2;
        logic [LIN_W-1:0] t1;
        logic [LIN_W-1:0] t2;
    } term_t;

    // floor square root, bit by bit
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bt;
        x   = v;
        res = 64'd0;
        for (int k = 0; k < 32; k++) begin
            bt = 64'd1 << (62 - 2 * k);
            if (x >= res + bt) begin
                x   = x - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
        end
        return res;
    endfunction

    // q1.30 factor 2^(2^-i), each from the previous one
    function automatic logic [30:0] exp_fac(input int i);
        logic [63:0] fac;
        fac = 64'd1 << 31;
        for (int j = 1; j <= i; j++) begin
            fac = isqrt64(fac << 30);
        end
        return fac[30:0];
    endfunction

endpackage

@@ sv/ehb_log2.sv @@
// pipelined base-2 log of an unsigned q4.28 value, signed q.24 result
// uses ehb_pkg
`timescale 1ns / 1ps

module ehb_log2 import ehb_pkg::*; (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [31:0]             val,
    output logic signed [LOG_W-1:0] lg
);

    logic [4:0]              p;
    logic [31:0]             shifted;
    logic [30:0]             m0;
    logic signed [LOG_W-1:0] l0;

    logic [30:0]             m_reg  [0:STEPS];
    logic signed [LOG_W-1:0] l_reg  [0:STEPS];
    logic [30:0]             m_next [1:STEPS];
    logic signed [LOG_W-1:0] l_next [1:STEPS];

    always_comb begin
        p = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (val[i]) p = 5'(i);
        end
        shifted = val << (5'd30 - p);
        m0 = (p == 5'd31) ? val[31:1] : shifted[30:0];
        l0 = LOG_W'($signed({2'b00, p}) - 7'sd28) <<< STEPS;
    end

    // one exact squaring per stage
    for (genvar g = 1; g <= STEPS; g++) begin : g_step
        logic [61:0] sq;
        assign sq = 62'(m_reg[g-1]) * 62'(m_reg[g-1]);
        assign m_next[g] = sq[61] ? sq[61:31] : sq[60:30];
        assign l_next[g] = l_reg[g-1] + (sq[61] ? (LOG_W'(1) <<< (STEPS - g)) : '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg[0] <= m0;
            l_reg[0] <= l0;
            for (int i = 1; i <= STEPS; i++) begin
                m_reg[i] <= m_next[i];
                l_reg[i] <= l_next[i];
            end
        end
    end

    assign lg = l_reg[STEPS];

endmodule

@@ sv/ehb_exp2.sv @@
// pipelined base-2 power of a signed q.24 log, unsigned q.32 result capped at 2^60
// uses ehb_pkg
`timescale 1ns / 1ps

module ehb_exp2 import ehb_pkg::*; (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [LOG_W-1:0] lg,
    output exp_out_t                res
);

    localparam int NW = LOG_W - STEPS;

    logic [30:0]          m_reg [0:STEPS];
    logic signed [NW-1:0] n_reg [0:STEPS];
    logic [STEPS-1:0]     f_reg [0:STEPS];
    logic [30:0]          m_next [1:STEPS];
    logic signed [NW:0]   sh;
    exp_out_t             res_next;
    exp_out_t             res_reg;

    for (genvar g = 1; g <= STEPS; g++) begin : g_step
        localparam logic [30:0] FAC = exp_fac(g);
        logic [61:0] prod;
        assign prod = 62'(m_reg[g-1]) * 62'(FAC);
        assign m_next[g] = f_reg[g-1][STEPS-g] ? prod[60:30] : m_reg[g-1];
    end

    always_comb begin
        sh = (NW+1)'(n_reg[STEPS]) + (NW+1)'(2);
        res_next.cap = 1'b0;
        if (sh >= (NW+1)'(30)) begin
            res_next.cap = 1'b1;
            res_next.val = LIN_W'(1) << 60;
        end else if (sh >= 0) begin
            res_next.val = LIN_W'(m_reg[STEPS]) << sh[4:0];
        end else if (sh <= -(NW+1)'(31)) begin
            res_next.val = '0;
        end else begin
            res_next.val = LIN_W'(m_reg[STEPS] >> 5'(-sh));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg[0] <= 31'h4000_0000;
            n_reg[0] <= lg[LOG_W-1:STEPS];
            f_reg[0] <= lg[STEPS-1:0];
            for (int i = 1; i <= STEPS; i++) begin
                m_reg[i] <= m_next[i];
                n_reg[i] <= n_reg[i-1];
                f_reg[i] <= f_reg[i-1];
            end
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

@@ sv/ehb_div.sv @@
// pipelined restoring divider, (num << 32) / den with num not above den
// uses ehb_pkg
`timescale 1ns / 1ps

module ehb_div import ehb_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [30:0] num,
    input  logic [30:0] den,
    output logic [32:0] quo
);

    localparam int NSTG = DIV_LAT - 1;

    logic [30:0] rem_reg [0:NSTG];
    logic [30:0] den_reg [0:NSTG];
    logic [32:0] q_reg   [0:NSTG];
    logic [30:0] rem_next [1:NSTG];
    logic        bit_next [1:NSTG];

    for (genvar g = 1; g <= NSTG; g++) begin : g_step
        logic [31:0] r2;
        assign r2 = {rem_reg[g-1], 1'b0};
        assign bit_next[g] = (r2 >= {1'b0, den_reg[g-1]});
        assign rem_next[g] = bit_next[g] ? 31'(r2 - {1'b0, den_reg[g-1]}) : r2[30:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // top quotient bit set when num is not below den
            rem_reg[0] <= (num >= den) ? 31'(num - den) : num;
            den_reg[0] <= den;
            q_reg[0]   <= {(num >= den), 32'd0};
            for (int i = 1; i <= NSTG; i++) begin
                rem_reg[i] <= rem_next[i];
                den_reg[i] <= den_reg[i-1];
                q_reg[i]   <= q_reg[i-1] | (33'(bit_next[i]) << (NSTG - i));
            end
        end
    end

    assign quo = q_reg[NSTG];

endmodule

@@ sv/ehb_delay.sv @@
// shift line that keeps side data level with the arithmetic pipeline
// uses ehb_pkg for nothing but house style
`timescale 1ns / 1ps

module ehb_delay import ehb_pkg::*; #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] dly_reg [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            dly_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign q = dly_reg[DEPTH-1];

endmodule

@@ sv/ellipsoidal_halo_bias_eval_unit.sv @@
// top level of the ellipsoidal halo bias unit: register port, item pipeline, output stage
// uses ehb_pkg, ehb_log2, ehb_exp2, ehb_div, ehb_delay and assert_macros.svh
`timescale 1ns / 1ps
// Usage
// s_tdata carries one sigma (unsigned q4.28) per request; m_tdata returns the bias
// (signed q12.20) and m_tuser its status: ok, saturated or invalid (zero divisor).
// Four registers (critical density, a, b, exponent c) sit on the apb port at 0x0,
// 0x4, 0x8 and 0xc; write them only while no request is in flight.
// Throughput: one request per cycle while no result waits or m_tready is high. A request
// passes the 24-step log pipeline, the 24-step exp pipeline and the 33-stage divider.
// The derived register values settle once a register write has passed the free-running derivation logic.
// When the receiver stalls the whole pipeline holds: s_tready follows m_tready while a
// result waits, and nothing is dropped or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and loads the default registers.
`include "assert_macros.svh"

module ellipsoidal_halo_bias_eval_unit import ehb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] sigma_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] bias_value
    output logic [1:0]  m_tuser,    // [1:0] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int S_LOG  = LOG_LAT;          // stage holding log of sigma
    localparam int S_X3   = S_LOG + 3;
    localparam int S_EXP  = S_X3 + EXP_LAT;
    localparam int S_D2   = S_EXP + 3;
    localparam int S_DIV  = S_D2 + DIV_LAT;
    localparam int S_M2   = S_DIV + 2;
    localparam int N_VLD  = S_M2 + 1;

    // registers
    logic [31:0] dc_reg, shape_a_reg, shape_b_reg;
    logic [28:0] exp_c_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dc_reg      <= RST_DC;
            shape_a_reg <= RST_A;
            shape_b_reg <= RST_B;
            exp_c_reg   <= RST_C;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_DC:  dc_reg      <= pwdata;
                REG_A:   shape_a_reg <= pwdata;
                REG_B:   shape_b_reg <= pwdata;
                REG_C:   exp_c_reg   <= pwdata[28:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DC:  prdata = dc_reg;
            REG_A:   prdata = shape_a_reg;
            REG_B:   prdata = shape_b_reg;
            REG_C:   prdata = {3'b000, exp_c_reg};
            default: prdata = '0;
        endcase
    end

    // values derived from the registers, running freely
    logic [28:0]             c_reg, omc_reg, tq_reg;
    logic [36:0]             kq_reg;
    logic [57:0]             tq_prod;
    logic [60:0]             kq_prod;
    logic [28:0]             half_c;
    logic signed [LOG_W-1:0] ld, la, lb, la_half;
    logic signed [LOG_W-1:0] arg3_reg;
    exp_out_t                e3;

    assign half_c  = Q28_ONE - (c_reg >> 1);
    assign tq_prod = 58'(omc_reg) * 58'(half_c);
    assign kq_prod = 61'(shape_b_reg) * 61'(tq_reg);
    assign la_half = (la < 0) ? -((-la) >>> 1) : (la >>> 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_reg   <= '0;
            omc_reg <= '0;
            tq_reg  <= '0;
            kq_reg  <= '0;
        end else begin
            c_reg   <= (exp_c_reg > Q28_ONE) ? Q28_ONE : exp_c_reg;
            omc_reg <= Q28_ONE - ((exp_c_reg > Q28_ONE) ? Q28_ONE : exp_c_reg);
            tq_reg  <= tq_prod[56:28];
            kq_reg  <= {kq_prod[60:28], 4'b0000};
        end
    end

    always_ff @(posedge aclk) begin
        arg3_reg <= -la_half - ld;
    end

    ehb_log2 u_log_dc (.aclk(aclk), .en(1'b1), .val(dc_reg),      .lg(ld));
    ehb_log2 u_log_a  (.aclk(aclk), .en(1'b1), .val(shape_a_reg), .lg(la));
    ehb_log2 u_log_b  (.aclk(aclk), .en(1'b1), .val(shape_b_reg), .lg(lb));
    ehb_exp2 u_exp_e3 (.aclk(aclk), .en(1'b1), .lg(arg3_reg),     .res(e3));

    // item pipeline, all stages advance together
    logic               en;
    logic [N_VLD-1:0]   vld_reg;
    logic               m_valid_reg;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[N_VLD-2:0], s_tvalid};
            m_valid_reg <= vld_reg[N_VLD-1];
        end
    end

    logic [31:0] sig_reg;
    logic        zero_reg;
    logic        zero_late;

    always_ff @(posedge aclk) begin
        if (en) begin
            sig_reg  <= s_tdata;
            zero_reg <= (s_tdata == 32'd0);
        end
    end

    ehb_delay #(.WIDTH(1), .DEPTH(S_M2)) u_dly_zero (
        .aclk(aclk), .en(en), .d(zero_reg), .q(zero_late)
    );

    logic signed [LOG_W-1:0] ls;
    ehb_log2 u_log_sig (.aclk(aclk), .en(en), .val(sig_reg), .lg(ls));

    // exponent arguments
    logic signed [LOG_W-1:0] lu_reg, lu2_reg, mag;
    logic signed [LOG_W-1:0] arg1_reg, arg2_reg, arg4_reg;
    logic [59:0]             p_omc_reg, p_c_reg;
    logic                    neg_reg;
    logic signed [LOG_W-1:0] sc_omc, sc_c;

    assign mag    = (lu_reg < 0) ? -lu_reg : lu_reg;
    assign sc_omc = neg_reg ? -LOG_W'(p_omc_reg[59:28]) : LOG_W'(p_omc_reg[59:28]);
    assign sc_c   = neg_reg ? -LOG_W'(p_c_reg[59:28])   : LOG_W'(p_c_reg[59:28]);

    always_ff @(posedge aclk) begin
        if (en) begin
            lu_reg    <= la + ((ld - ls) <<< 1);
            p_omc_reg <= 60'(mag[30:0]) * 60'(omc_reg);
            p_c_reg   <= 60'(mag[30:0]) * 60'(c_reg);
            neg_reg   <= (lu_reg < 0);
            lu2_reg   <= lu_reg;
            arg1_reg  <= lu2_reg - ld;
            arg2_reg  <= lb + sc_omc - ld;
            arg4_reg  <= sc_c;
        end
    end

    exp_out_t e1, e2, e4;
    ehb_exp2 u_exp_t1 (.aclk(aclk), .en(en), .lg(arg1_reg), .res(e1));
    ehb_exp2 u_exp_t2 (.aclk(aclk), .en(en), .lg(arg2_reg), .res(e2));
    ehb_exp2 u_exp_uc (.aclk(aclk), .en(en), .lg(arg4_reg), .res(e4));

    term_t terms_in, terms_late;
    assign terms_in = '{cap1: e1.cap, cap2: e2.cap, t1: e1.val, t2: e2.val};

    ehb_delay #(.WIDTH($bits(term_t)), .DEPTH(S_DIV + 1 - S_EXP)) u_dly_terms (
        .aclk(aclk), .en(en), .d(terms_in), .q(terms_late)
    );

    // ratio u^c / (u^c + k)
    logic [61:0] uc_reg, d_reg, uc2_reg, d2_reg;
    logic [5:0]  s_reg;
    logic [5:0]  s_next;
    logic [30:0] num_reg, den_reg;
    logic [61:0] num_sh, den_sh;

    always_comb begin
        s_next = 6'd0;
        for (int i = 31; i < 62; i++) begin
            if (d_reg[i]) s_next = 6'(i - 30);
        end
    end

    assign num_sh = uc2_reg >> s_reg;
    assign den_sh = d2_reg >> s_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            uc_reg  <= 62'(e4.val);
            d_reg   <= 62'(e4.val) + 62'(kq_reg);
            uc2_reg <= uc_reg;
            d2_reg  <= d_reg;
            s_reg   <= s_next;
            num_reg <= num_sh[30:0];
            den_reg <= den_sh[30:0];
        end
    end

    logic [32:0] quo;
    ehb_div u_div (.aclk(aclk), .en(en), .num(num_reg), .den(den_reg), .quo(quo));

    // combine terms
    logic [32:0]        r;
    logic [61:0]        ph_reg;
    logic [32:0]        pl_reg;
    logic [64:0]        pl_full;
    logic signed [63:0] acc_reg;
    logic               cap_reg;
    logic [62:0]        t3;
    logic [LIN_W-1:0]   t2m;
    logic signed [63:0] rnd;
    logic               hi_clip, lo_clip;

    assign r       = (kq_reg == '0) ? 33'h1_0000_0000 : quo;
    assign pl_full = 65'(e3.val[31:0]) * 65'(r);
    assign t3      = 63'(ph_reg) + 63'(pl_reg);
    assign t2m     = (shape_b_reg == 32'd0) ? '0 : terms_late.t2;

    always_ff @(posedge aclk) begin
        if (en) begin
            ph_reg  <= 62'(e3.val[60:32]) * 62'(r);
            pl_reg  <= pl_full[64:32];
            acc_reg <= 64'sh1_0000_0000 + $signed(64'(terms_late.t1)) + $signed(64'(t2m))
                       - $signed(64'(t3));
            cap_reg <= terms_late.cap1 || (terms_late.cap2 && shape_b_reg != 32'd0)
                       || e3.cap;
        end
    end

    // round half up to q12.20 and clamp
    assign rnd     = (acc_reg + 64'sd2048) >>> 12;
    assign hi_clip = rnd > 64'sd2147483647;
    assign lo_clip = rnd < -64'sd2147483648;

    logic [31:0] bias_reg;
    logic [1:0]  status_reg;
    logic        inv;

    assign inv = zero_late || dc_reg == 32'd0 || shape_a_reg == 32'd0;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (inv) begin
                bias_reg   <= '0;
                status_reg <= ST_INVALID;
            end else begin
                bias_reg   <= hi_clip ? 32'h7fff_ffff : (lo_clip ? 32'h8000_0000 : rnd[31:0]);
                status_reg <= (cap_reg || hi_clip || lo_clip) ? ST_SAT : ST_OK;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = bias_reg;
    assign m_tuser  = status_reg;

    `EHB_ASSERT(a_inv_zero, m_tvalid && m_tuser == ST_INVALID, m_tdata == 32'd0, "invalid result with nonzero bias")
    `EHB_ASSERT_NEXT(a_rst_empty, !aresetn, !m_tvalid && vld_reg == '0, "pipeline not empty after reset")
    `EHB_ASSERT_NEXT(a_kq_zero, aresetn && shape_b_reg == 32'd0, kq_reg == '0, "k term nonzero with b zero")

endmodule

@@ tb/ehb_checker.sv @@
// halo bias checker: snoops the register port and both streams, predicts each bias and
// status from sigma and the current registers, and compares in order. uses ehb_pkg
`timescale 1ns / 1ps

module ehb_checker import ehb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] sigma_value
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,    // [31:0] bias_value
    input  logic [1:0]  m_tuser,    // [1:0] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending,
    output int          checked,
    output int          n_sat,
    output int          n_invalid
);

    localparam longint LOG_UNIT = 64'sd16777216;
    localparam logic [63:0] LIN_LIMIT = 64'd1 << 60;
    localparam logic [63:0] UNIT28 = 64'd268435456;

    typedef struct packed {
        logic [31:0] bias;
        logic [1:0]  status;
    } bias_res_t;

    logic [31:0] dc_reg, a_reg, b_reg;
    logic [28:0] c_reg;
    logic [63:0] root_fac [1:24];
    bias_res_t   bias_q[$];

    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] rem, acc, bt;
        rem = v;
        acc = 0;
        for (int k = 31; k >= 0; k--) begin
            bt = 64'd1 << (2 * k);
            if (rem >= acc + bt) begin
                rem = rem - (acc + bt);
                acc = (acc >> 1) + bt;
            end else begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

    initial begin
        logic [63:0] f;
        f = 64'd1 << 31;
        for (int i = 1; i <= 24; i++) begin
            f = floor_root(f << 30);
            root_fac[i] = f;
        end
    end

    // base-2 log of a nonzero q4.28 value, signed q.24
    function automatic longint log_q24(input logic [31:0] v);
        int p;
        logic [63:0] m;
        longint lg;
        p = 31;
        while (p > 0 && !v[p]) p--;
        m = (p <= 30) ? (64'(v) << (30 - p)) : (64'(v) >> 1);
        lg = longint'(p - 28) * LOG_UNIT;
        for (int i = 23; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                lg += 64'sd1 << i;
            end
        end
        return lg;
    endfunction

    function automatic longint log_times(input longint lg, input logic [63:0] qf);
        logic [63:0] mag;
        mag = (lg < 0) ? 64'(-lg) : 64'(lg);
        mag = (mag * qf) >> 28;
        return (lg < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // 2^lg as unsigned q.32, capped at 2^60
    function automatic logic [63:0] pow2_lin(input longint lg, inout logic capped);
        longint n, f, sh;
        logic [63:0] m;
        m = 64'd1 << 30;
        if (lg >= 0) n = lg / LOG_UNIT;
        else n = -((-lg + LOG_UNIT - 1) / LOG_UNIT);
        f = lg - n * LOG_UNIT;
        for (int i = 1; i <= 24; i++)
            if (f[24-i]) m = (m * root_fac[i]) >> 30;
        sh = n + 2;
        if (sh >= 30) begin
            capped = 1'b1;
            return LIN_LIMIT;
        end
        if (sh >= 0) return m << sh;
        if (-sh >= 63) return 0;
        return m >> (-sh);
    endfunction

    function automatic bias_res_t halo_bias(input logic [31:0] sig);
        bias_res_t r;
        logic [63:0] c, omc, t, kq, uc, e3, ratio, t1, t2, t3, d, num, tmp;
        longint ld, ls, la, lu, acc, q;
        logic sat, ignore;
        int s;
        sat = 0;
        ignore = 0;
        s = 0;
        t2 = 0;
        if (sig == 0 || dc_reg == 0 || a_reg == 0) begin
            r.bias = 0;
            r.status = ST_INVALID;
            return r;
        end
        c = (64'(c_reg) > UNIT28) ? UNIT28 : 64'(c_reg);
        omc = UNIT28 - c;
        ld = log_q24(dc_reg);
        ls = log_q24(sig);
        la = log_q24(a_reg);
        lu = la + 2 * (ld - ls);
        t1 = pow2_lin(lu - ld, sat);
        if (b_reg != 0)
            t2 = pow2_lin(log_q24(b_reg) + log_times(lu, omc) - ld, sat);
        t = (omc * (UNIT28 - (c >> 1))) >> 28;
        kq = ((64'(b_reg) * t) >> 28) << 4;
        e3 = pow2_lin(-(la / 2) - ld, sat);
        if (kq == 0) begin
            ratio = 64'd1 << 32;
        end else begin
            // capped u^c does not flag saturation
            uc = pow2_lin(log_times(lu, c), ignore);
            d = uc + kq;
            while ((d >> s) >= (64'd1 << 31)) s++;
            num = uc >> s;
            ratio = (num << 32) / (d >> s);
        end
        t3 = (e3 >> 32) * ratio + (((e3 & 64'hFFFF_FFFF) * ratio) >> 32);
        acc = (64'sd1 <<< 32) + longint'(t1) + longint'(t2) - longint'(t3);
        tmp = 64'(acc + (64'sd1 <<< 62)) + 64'd2048;
        q = longint'(tmp >> 12) - (64'sd1 <<< 50);
        if (q > 64'sd2147483647) begin
            q = 64'sd2147483647;
            sat = 1;
        end
        if (q < -64'sd2147483648) begin
            q = -64'sd2147483648;
            sat = 1;
        end
        r.bias = q[31:0];
        r.status = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    assign pending = bias_q.size();

    always @(posedge aclk) begin
        bias_res_t want;
        int errs;
        errs = 0;
        if (!aresetn) begin
            dc_reg <= RST_DC;
            a_reg  <= RST_A;
            b_reg  <= RST_B;
            c_reg  <= RST_C;
            bias_q.delete();
            fail_count <= 0;
            checked <= 0;
            n_sat <= 0;
            n_invalid <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_DC:  dc_reg <= pwdata;
                    REG_A:   a_reg  <= pwdata;
                    REG_B:   b_reg  <= pwdata;
                    REG_C:   c_reg  <= pwdata[28:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                bias_q.push_back(halo_bias(s_tdata));
            if (m_tvalid && m_tready) begin
                checked <= checked + 1;
                if (m_tuser == ST_SAT) n_sat <= n_sat + 1;
                if (m_tuser == ST_INVALID) n_invalid <= n_invalid + 1;
                if (bias_q.size() == 0) begin
                    $error("unexpected result: bias_value %h status %0d", m_tdata, m_tuser);
                    errs = errs + 1;
                end else begin
                    want = bias_q.pop_front();
                    if (m_tdata !== want.bias) begin
                        $error("bias_value: expected %h, got %h", want.bias, m_tdata);
                        errs = errs + 1;
                    end
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        errs = errs + 1;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end

endmodule

@@ tb/tb.sv @@
// halo bias testbench top: clock, reset, register phases, sigma stimulus and verdict
// uses ehb_pkg, ehb_checker and the ellipsoidal_halo_bias_eval_unit block
`timescale 1ns / 1ps

module tb import ehb_pkg::*;;

    localparam int CYCLE_LIMIT = 600000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid, s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid, m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        psel, penable, pwrite, pready;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        s_acc_q;
    logic        no_gaps;
    int          fail_count, pending, checked, n_sat, n_invalid;
    int          cycles;

    ellipsoidal_halo_bias_eval_unit dut (.*);

    ehb_checker chk (.*);

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    always @(posedge aclk) s_acc_q <= s_tvalid && s_tready;

    always @(negedge aclk) m_tready <= no_gaps || ($urandom_range(0, 99) >= 28);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_sigma(input logic [31:0] v);
        while (!no_gaps && $urandom_range(0, 99) < 28) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(negedge aclk); while (!s_acc_q);
    endtask

    // mostly a random sigma shifted right by up to 8 bits, sometimes any 32-bit pattern
    function automatic logic [31:0] rand_sigma();
        logic [31:0] v;
        v = $urandom();
        if ($urandom_range(0, 3) != 0) v = v >> $urandom_range(0, 8);
        return v;
    endfunction

    // wait for every request to return, then let derived registers settle
    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    task automatic run_phase(input logic [31:0] dc, input logic [31:0] a,
                             input logic [31:0] b, input logic [31:0] c, input int n);
        drain_and_settle();
        write_reg(REG_DC, dc);
        write_reg(REG_A, a);
        write_reg(REG_B, b);
        write_reg(REG_C, c);
        repeat (70) @(negedge aclk);
        for (int i = 0; i < n; i++) send_sigma(rand_sigma());
    endtask

    initial begin
        logic [31:0] directed [$];
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = 0;
        pwdata   = 0;
        no_gaps  = 1'b0;
        cycles   = 0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        repeat (70) @(negedge aclk);

        // default registers: zero, tiny, unity, huge and single-bit sigmas
        directed = '{32'd0, 32'd1, 32'd2, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1000_0000,
                     32'h0800_0000, 32'h2000_0000, 32'h0000_1000, 32'h0010_0000,
                     32'h7FFF_FFFF, 32'h0FFF_FFFF, 32'h1A2B_3C4D, 32'h0003_0000,
                     32'hAAAA_AAAA, 32'h5555_5555};
        foreach (directed[i]) send_sigma(directed[i]);
        for (int i = 0; i < 200; i++) send_sigma(rand_sigma());

        // burst with neither side idling
        no_gaps = 1'b1;
        for (int i = 0; i < 150; i++) send_sigma(rand_sigma());
        no_gaps = 1'b0;

        run_phase(RST_DC, RST_A, RST_B, 32'h1FFF_FFFF, 80);        // exponent above one
        run_phase(RST_DC, RST_A, RST_B, 32'd0, 80);                 // exponent zero
        run_phase(RST_DC, RST_A, 32'd0, RST_C, 80);                 // no b terms
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1000_0000, 80);
        run_phase(32'd1, 32'd1, 32'd1, 32'd1, 60);
        run_phase(32'd0, RST_A, RST_B, RST_C, 30);                  // zero density
        run_phase(RST_DC, 32'd0, RST_B, RST_C, 30);                 // zero a
        for (int k = 0; k < 6; k++)
            run_phase($urandom(), $urandom(), $urandom(), $urandom_range(0, 32'h1FFF_FFFF),
                      60);
        run_phase(RST_DC, RST_A, RST_B, RST_C, 60);

        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (150) @(negedge aclk);

        $display("checked %0d bias results over 15 register settings", checked);
        $display("%0d saturated, %0d invalid, %0d mismatches", n_sat, n_invalid, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/ehb_pkg.sv
sv/ehb_log2.sv
sv/ehb_exp2.sv
sv/ehb_div.sv
sv/ehb_delay.sv
sv/ellipsoidal_halo_bias_eval_unit.sv
tb/ehb_checker.sv
tb/tb.sv
